/* hw/rtl/rtcd_pkg.sv */
package rtcd_pkg;

  // Limits of the decoded picture
  localparam int unsigned MAX_WIDTH  = 1024;
  localparam int unsigned MAX_HEIGHT = 256;
  localparam int unsigned MAX_RULES  = 8;

  // Field and counter widths
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned LEN_W   = 19;
  localparam int unsigned LC_W    = 11;
  localparam int unsigned TC_W    = 19;
  localparam int unsigned HGT_W   = 9;
  localparam int unsigned AREA_W  = LC_W + HGT_W;
  localparam int unsigned RULES_W = 64;
  localparam int unsigned RCNT_W  = 4;
  localparam int unsigned CIDX_W  = 3;
  localparam int unsigned ST_W    = 3;
  localparam int unsigned SUM_W   = LEN_W + 1;
  localparam int unsigned MUL_W   = LEN_W + 4;

  localparam logic [LEN_W-1:0] RUN_MAX   = LEN_W'(MAX_WIDTH * MAX_HEIGHT);
  localparam logic [LC_W-1:0]  LINE_SAT  = '1;
  localparam logic [TC_W-1:0]  TOTAL_SAT = '1;

  // Register reset values
  localparam logic [LC_W-1:0]   LINE_WIDTH_RST   = LC_W'(170);
  localparam logic [HGT_W-1:0]  CHUNK_HEIGHT_RST = HGT_W'(48);
  localparam logic [AREA_W-1:0] AREA_RST         = AREA_W'(170 * 48);

  // Characters
  localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CHAR_NL    = 8'h0A;
  localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'h39;

  // Result queue
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [3:0] {
    MODE_FRESH = 4'b0001,
    MODE_AFTER = 4'b0010,
    MODE_SYM   = 4'b0100,
    MODE_DIG   = 4'b1000
  } mode_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK      = 3'd0,
    ST_BAD_SYM = 3'd1,
    ST_LINE    = 3'd2,
    ST_SIZE    = 3'd3,
    ST_MISSING = 3'd4
  } status_e;

  typedef enum logic [CIDX_W-1:0] {
    CFG_MARKER    = 3'd0,
    CFG_WIDTH     = 3'd1,
    CFG_HEIGHT    = 3'd2,
    CFG_RULES     = 3'd3,
    CFG_RULE_CNT  = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [BYTE_W-1:0]  marker;
    logic [LC_W-1:0]    line_width;
    logic [AREA_W-1:0]  area;
    logic [RULES_W-1:0] rules;
    logic [RCNT_W-1:0]  rule_cnt;
  } cfg_t;

  typedef struct packed {
    logic [BYTE_W-1:0] symbol;
    logic [LEN_W-1:0]  run_length;
  } run_t;

  // Everything one input byte produces: up to two runs plus chunk status
  typedef struct packed {
    run_t    run0;
    run_t    run1;
    logic    two;
    status_e status;
    logic    done;
  } rec_t;

  function automatic logic rtcd_sym_ok(logic [BYTE_W-1:0] b, logic [RULES_W-1:0] rules,
                                       logic [RCNT_W-1:0] cnt);
    logic [RCNT_W-1:0] n;
    logic              hit;
    n   = (cnt > RCNT_W'(MAX_RULES)) ? RCNT_W'(MAX_RULES) : cnt;
    hit = (b == CHAR_SPACE);
    for (int k = 0; k < MAX_RULES; k++) begin
      if ((RCNT_W'(k) < n) && (rules[BYTE_W*k +: BYTE_W] == b)) begin
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

endpackage

/* hw/rtl/rtcd_if.sv */
interface rtcd_in_if import rtcd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;
  logic              chunk_end;

  modport source (output valid, in_byte, chunk_end, input ready);
  modport sink (input valid, in_byte, chunk_end, output ready);
endinterface

interface rtcd_out_if import rtcd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] symbol;
  logic [LEN_W-1:0]  run_length;
  logic [ST_W-1:0]   status;
  logic              chunk_done;
  logic              last;

  modport source (output valid, symbol, run_length, status, chunk_done, last, input ready);
  modport sink (input valid, symbol, run_length, status, chunk_done, last, output ready);
endinterface

interface rtcd_cfg_if import rtcd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CIDX_W-1:0]  index;
  logic [RULES_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* hw/rtl/rtcd_front.sv */
module rtcd_front import rtcd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  rtcd_in_if.sink    in_i,
  input  logic       q_ready_i,
  output logic       q_push_o,
  output rec_t       q_rec_o
);

  mode_e             mode_q, mode_d;
  logic [BYTE_W-1:0] held_q, held_d;
  logic [LEN_W-1:0]  acc_q, acc_d;
  logic              dseen_q, dseen_d;
  logic [LC_W-1:0]   lc_q, lc_a, lc_b, lc_c;
  logic [TC_W-1:0]   tc_q, tc_a, tc_b, tc_c;
  status_e           err_q, err_d, st;

  logic [BYTE_W-1:0] b;
  logic              fire, b_ok, is_digit, do_take;
  logic              grp_run, lit_run, end_run;
  logic [3:0]        digit;
  logic [MUL_W-1:0]  acc_x10;
  logic [SUM_W-1:0]  lc_sum_a, lc_sum_b, lc_sum_c;
  logic [SUM_W-1:0]  tc_sum_a, tc_sum_b, tc_sum_c;

  assign b           = in_i.in_byte;
  assign fire        = in_i.valid && q_ready_i;
  assign in_i.ready  = q_ready_i;
  assign b_ok        = rtcd_sym_ok(b, cfg_i.rules, cfg_i.rule_cnt);
  assign is_digit    = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
  assign digit       = 4'(b - CHAR_ZERO);
  assign acc_x10     = ({4'd0, acc_q} << 3) + ({4'd0, acc_q} << 1) + {19'd0, digit};

  always_comb begin
    mode_d  = mode_q;
    held_d  = held_q;
    acc_d   = acc_q;
    dseen_d = dseen_q;
    err_d   = err_q;
    grp_run = 1'b0;
    lit_run = 1'b0;
    end_run = 1'b0;
    do_take = 1'b0;

    // Symbol, digits, or a plain element
    if (err_q == ST_OK) begin
      unique case (mode_q)
        MODE_SYM: begin
          held_d = b;
          if (!b_ok) begin
            err_d = ST_BAD_SYM;
          end else begin
            mode_d  = MODE_DIG;
            acc_d   = '0;
            dseen_d = 1'b0;
          end
        end
        MODE_DIG: begin
          if (is_digit) begin
            acc_d   = (acc_x10 > {4'd0, RUN_MAX}) ? RUN_MAX : acc_x10[LEN_W-1:0];
            dseen_d = 1'b1;
          end else if (!dseen_q) begin
            err_d = ST_MISSING;
          end else begin
            grp_run = (acc_q != '0);
            acc_d   = '0;
            dseen_d = 1'b0;
            mode_d  = MODE_AFTER;
            do_take = 1'b1;
          end
        end
        default: begin
          do_take = 1'b1;
        end
      endcase
    end

    lc_sum_a = {9'd0, lc_q} + {1'b0, acc_q};
    tc_sum_a = {1'b0, tc_q} + {1'b0, acc_q};
    lc_a     = lc_q;
    tc_a     = tc_q;
    if (grp_run) begin
      lc_a = (lc_sum_a > SUM_W'(LINE_SAT)) ? LINE_SAT : lc_sum_a[LC_W-1:0];
      tc_a = tc_sum_a[TC_W] ? TOTAL_SAT : tc_sum_a[TC_W-1:0];
    end

    lc_sum_b = {9'd0, lc_a} + SUM_W'(1);
    tc_sum_b = {1'b0, tc_a} + SUM_W'(1);
    lc_b     = lc_a;
    tc_b     = tc_a;
    if (do_take) begin
      priority if ((mode_d == MODE_AFTER) && (b == CHAR_NL)) begin
        if (lc_a != cfg_i.line_width) begin
          err_d = ST_LINE;
        end else begin
          lc_b   = '0;
          mode_d = MODE_FRESH;
        end
      end else if (b == cfg_i.marker) begin
        mode_d = MODE_SYM;
      end else if (b_ok) begin
        lit_run = 1'b1;
        lc_b    = (lc_sum_b > SUM_W'(LINE_SAT)) ? LINE_SAT : lc_sum_b[LC_W-1:0];
        tc_b    = tc_sum_b[TC_W] ? TOTAL_SAT : tc_sum_b[TC_W-1:0];
        mode_d  = MODE_AFTER;
      end else begin
        err_d = ST_BAD_SYM;
      end
    end

    // Close the chunk: flush an open group, then check line and total
    st = err_d;
    if (in_i.chunk_end && (err_d == ST_OK)) begin
      if (mode_d == MODE_SYM) begin
        st = ST_MISSING;
      end else if (mode_d == MODE_DIG) begin
        if (dseen_d) begin
          end_run = (acc_d != '0);
        end else begin
          st = ST_MISSING;
        end
      end
    end

    lc_sum_c = {9'd0, lc_b} + {1'b0, acc_d};
    tc_sum_c = {1'b0, tc_b} + {1'b0, acc_d};
    lc_c     = lc_b;
    tc_c     = tc_b;
    if (end_run) begin
      lc_c = (lc_sum_c > SUM_W'(LINE_SAT)) ? LINE_SAT : lc_sum_c[LC_W-1:0];
      tc_c = tc_sum_c[TC_W] ? TOTAL_SAT : tc_sum_c[TC_W-1:0];
    end
    if (st == ST_OK) begin
      if (lc_c != cfg_i.line_width) begin
        st = ST_LINE;
      end else if ({1'b0, tc_c} != cfg_i.area) begin
        st = ST_SIZE;
      end
    end

    // Pack the results of this byte
    q_rec_o.run0 = '0;
    q_rec_o.run1 = '0;
    priority if (grp_run) begin
      q_rec_o.run0 = '{symbol: held_q, run_length: acc_q};
    end else if (lit_run) begin
      q_rec_o.run0 = '{symbol: b, run_length: LEN_W'(1)};
    end else if (end_run) begin
      q_rec_o.run0 = '{symbol: held_d, run_length: acc_d};
    end else begin
      q_rec_o.run0 = '0;
    end
    if (grp_run && lit_run) begin
      q_rec_o.run1 = '{symbol: b, run_length: LEN_W'(1)};
    end
    q_rec_o.two    = grp_run && lit_run;
    q_rec_o.status = in_i.chunk_end ? st : ST_OK;
    q_rec_o.done   = in_i.chunk_end;
    q_push_o       = fire && (grp_run || lit_run || end_run || in_i.chunk_end);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_FRESH;
      held_q  <= '0;
      acc_q   <= '0;
      dseen_q <= 1'b0;
      lc_q    <= '0;
      tc_q    <= '0;
      err_q   <= ST_OK;
    end else if (fire) begin
      if (in_i.chunk_end) begin
        mode_q  <= MODE_FRESH;
        held_q  <= '0;
        acc_q   <= '0;
        dseen_q <= 1'b0;
        lc_q    <= '0;
        tc_q    <= '0;
        err_q   <= ST_OK;
      end else begin
        mode_q  <= mode_d;
        held_q  <= held_d;
        acc_q   <= acc_d;
        dseen_q <= dseen_d;
        lc_q    <= lc_b;
        tc_q    <= tc_b;
        err_q   <= err_d;
      end
    end
  end

endmodule

/* hw/rtl/rtcd_queue.sv */
module rtcd_queue import rtcd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  rec_t rec_i,
  output logic ready_o,
  input  logic pop_i,
  output logic valid_o,
  output rec_t rec_o
);

  rec_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              do_push, do_pop;

  assign ready_o = (cnt_q != QCNT_W'(QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign rec_o   = mem_q[rd_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= rec_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wr_q + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_q <= rd_q + QPTR_W'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + QCNT_W'(1);
        2'b01:   cnt_q <= cnt_q - QCNT_W'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

/* hw/rtl/rtcd_back.sv */
module rtcd_back import rtcd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_valid_i,
  input  rec_t       q_rec_i,
  output logic       q_pop_o,
  rtcd_out_if.source out_o
);

  rec_t rec_q;
  logic busy_q;
  logic idx_q;
  logic is_last;
  run_t cur;

  assign is_last = idx_q || !rec_q.two;
  assign cur     = idx_q ? rec_q.run1 : rec_q.run0;
  assign q_pop_o = q_valid_i && (!busy_q || (out_o.ready && is_last));

  assign out_o.valid      = busy_q;
  assign out_o.symbol     = cur.symbol;
  assign out_o.run_length = cur.run_length;
  assign out_o.status     = is_last ? rec_q.status : ST_OK;
  assign out_o.chunk_done = is_last && rec_q.done;
  assign out_o.last       = is_last;

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      rec_q <= q_rec_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= 1'b0;
    end else if (q_pop_o) begin
      busy_q <= 1'b1;
      idx_q  <= 1'b0;
    end else if (busy_q && out_o.ready) begin
      if (is_last) begin
        busy_q <= 1'b0;
      end else begin
        idx_q <= 1'b1;
      end
    end
  end

endmodule

/* hw/rtl/rle_text_chunk_decoder_top.sv */
// Run-length text chunk decoder.
//
// in_i carries one byte of chunk text per beat; chunk_end marks the final
// byte. out_o carries run descriptors (symbol, run_length) in order. A
// result beat with chunk_done set closes the chunk and holds its status
// (ok, bad symbol, line length, chunk size, missing count); when the final
// byte yields no run, that beat is status-only with run_length 0. last is
// set on the final beat produced by each input byte.
// cfg_i writes one register per beat (index 0..4: marker, line width,
// chunk height, rule symbols, rule count); it is always ready. Write it
// only while no chunk is in flight.
// Results pass through the result queue, then the back stage's register.
// One byte is taken per cycle while the queue has room; the output port
// delivers one beat per cycle while out_o is ready, so a byte that closes
// a group and adds a literal yields two output beats. A four-entry result
// queue absorbs these and output stalls; in_i drops ready only when full.
// Reset clears all parse state, empties the queue and restores register
// defaults (width 170, height 48, no rules, marker 0).
module rle_text_chunk_decoder_top import rtcd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  rtcd_in_if.sink    in_i,
  rtcd_out_if.source out_o,
  rtcd_cfg_if.sink   cfg_i
);

  logic [BYTE_W-1:0]  marker_q;
  logic [LC_W-1:0]    width_q, width_d;
  logic [HGT_W-1:0]   height_q, height_d;
  logic [RULES_W-1:0] rules_q;
  logic [RCNT_W-1:0]  rcnt_q;
  logic [AREA_W-1:0]  area_q;
  cfg_t               cfg;

  logic q_push, q_ready, q_pop, q_valid;
  rec_t q_wr_rec, q_rd_rec;

  // Config register bank; take every beat, ignore unknown indexes
  assign cfg_i.ready = 1'b1;

  // Next width and height, so the expected chunk size lands with them
  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    if (cfg_i.valid && (cfg_i.index == CFG_WIDTH)) begin
      width_d = cfg_i.data[LC_W-1:0];
    end
    if (cfg_i.valid && (cfg_i.index == CFG_HEIGHT)) begin
      height_d = cfg_i.data[HGT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      marker_q <= '0;
      width_q  <= LINE_WIDTH_RST;
      height_q <= CHUNK_HEIGHT_RST;
      rules_q  <= '0;
      rcnt_q   <= '0;
      area_q   <= AREA_RST;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
      area_q   <= AREA_W'(width_d) * AREA_W'(height_d);
      if (cfg_i.valid) begin
        unique case (cfg_i.index)
          CFG_MARKER:   marker_q <= cfg_i.data[BYTE_W-1:0];
          CFG_RULES:    rules_q  <= cfg_i.data;
          CFG_RULE_CNT: rcnt_q   <= cfg_i.data[RCNT_W-1:0];
          default:      marker_q <= marker_q;
        endcase
      end
    end
  end

  assign cfg = '{marker: marker_q, line_width: width_q, area: area_q,
                 rules: rules_q, rule_cnt: rcnt_q};

  // Front: parse bytes, keep line and chunk counters, pack results
  rtcd_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .in_i      (in_i),
    .q_ready_i (q_ready),
    .q_push_o  (q_push),
    .q_rec_o   (q_wr_rec)
  );

  // Queue: one entry per byte that yields results
  rtcd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .rec_i   (q_wr_rec),
    .ready_o (q_ready),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .rec_o   (q_rd_rec)
  );

  // Back: hand out each entry's runs one beat at a time
  rtcd_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_rec_i   (q_rd_rec),
    .q_pop_o   (q_pop),
    .out_o     (out_o)
  );

  // An error status only ever appears on the closing beat
  a_status_on_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && (out_o.status != ST_OK) |-> out_o.chunk_done)
    else $error("error status on a beat that does not close the chunk");

  // The closing beat is the final beat of its byte
  a_close_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.chunk_done |-> out_o.last)
    else $error("chunk closed before the last beat of its byte");

  // Only the closing beat may carry an empty run
  a_no_empty_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.chunk_done |-> (out_o.run_length != '0))
    else $error("empty run outside a closing beat");

  // The queue never takes a push while full
  a_queue_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> q_ready)
    else $error("result pushed into a full queue");

endmodule

/* sim/tb.sv */
`timescale 1ns / 100ps

module tb;
  import rtcd_pkg::*;

  // Stimulus and checking knobs
  localparam int unsigned ITEM_TARGET    = 1200;  // bytes of chunk text to send
  localparam int unsigned PHASE_BYTES    = 120;   // bytes per register setting
  localparam int unsigned SETTLE_CYCLES  = 8;     // drain margin after the last result
  localparam int unsigned HOLD_AT        = 400;   // bytes taken before the long hold-off
  localparam int unsigned HOLD_CYCLES    = 200;
  localparam int unsigned QUIET_LIMIT    = 3000;  // cycles without any beat
  localparam logic [BYTE_W-1:0] DIR_MARK = 8'hFF;

  // One byte of chunk text as the sender offers it
  typedef struct packed {
    logic [BYTE_W-1:0] value;
    logic              fin;
  } text_byte_t;

  // One decoded run descriptor as the block should deliver it
  typedef struct packed {
    logic [BYTE_W-1:0] symbol;
    logic [LEN_W-1:0]  run_length;
    status_e           status;
    logic              chunk_done;
    logic              byte_last;
  } run_beat_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  rtcd_in_if  in_if ();
  rtcd_out_if out_if ();
  rtcd_cfg_if cfg_if ();

  rle_text_chunk_decoder_top u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Register copy used by the decoder prediction, updated on each write beat
  logic [BYTE_W-1:0]  cfg_marker   = '0;
  logic [LC_W-1:0]    cfg_width    = LINE_WIDTH_RST;
  logic [HGT_W-1:0]   cfg_height   = CHUNK_HEIGHT_RST;
  logic [RULES_W-1:0] cfg_rules    = '0;
  logic [RCNT_W-1:0]  cfg_rule_cnt = '0;

  // Per-chunk decode state
  mode_e             dec_mode   = MODE_FRESH;
  logic [BYTE_W-1:0] dec_held   = '0;
  logic [LEN_W-1:0]  dec_count  = '0;
  logic              dec_digits = 1'b0;
  logic [LC_W-1:0]   dec_line   = '0;
  logic [TC_W-1:0]   dec_total  = '0;
  status_e           dec_err    = ST_OK;

  run_beat_t  byte_runs[$];     // runs caused by the byte being decoded
  run_beat_t  run_expect_q[$];  // runs still owed by the block, oldest first
  text_byte_t text_q[$];        // bytes waiting for the sender
  logic [BYTE_W-1:0] chunk_txt[$];
  logic [BYTE_W-1:0] sym_pool[$];  // symbols a well-formed chunk may use

  int unsigned bytes_queued = 0;
  int unsigned bytes_taken  = 0;
  int unsigned fail_cnt     = 0;
  logic        byte_beat    = 1'b0;

  // ---------------------------------------------------------------------------
  // Decoder prediction
  // ---------------------------------------------------------------------------

  function automatic logic symbol_allowed(logic [BYTE_W-1:0] b);
    int unsigned n;
    logic        hit;
    n   = (cfg_rule_cnt > MAX_RULES) ? MAX_RULES : cfg_rule_cnt;
    hit = (b == CHAR_SPACE);
    for (int k = 0; k < n; k++) begin
      if (cfg_rules[BYTE_W*k +: BYTE_W] == b) hit = 1'b1;
    end
    return hit;
  endfunction

  // Count a run into the line and chunk totals; zero-length runs vanish
  function automatic void push_run(logic [BYTE_W-1:0] sym, logic [LEN_W-1:0] len);
    int unsigned sum;
    run_beat_t   r;
    if (len == 0) return;
    sum       = dec_line + len;
    dec_line  = (sum > LINE_SAT) ? LINE_SAT : LC_W'(sum);
    sum       = dec_total + len;
    dec_total = (sum > TOTAL_SAT) ? TOTAL_SAT : TC_W'(sum);
    r            = '0;
    r.symbol     = sym;
    r.run_length = len;
    r.status     = ST_OK;
    byte_runs.insert(byte_runs.size(), r);
  endfunction

  // A literal, a marker, or a newline closing a line after an element
  function automatic void take_element(logic [BYTE_W-1:0] b);
    if (dec_mode == MODE_AFTER && b == CHAR_NL) begin
      if (dec_line != cfg_width) begin
        dec_err = ST_LINE;
      end else begin
        dec_line = '0;
        dec_mode = MODE_FRESH;
      end
    end else if (b == cfg_marker) begin
      dec_mode = MODE_SYM;
    end else if (symbol_allowed(b)) begin
      push_run(b, LEN_W'(1));
      dec_mode = MODE_AFTER;
    end else begin
      dec_err = ST_BAD_SYM;
    end
  endfunction

  function automatic void decode_byte(logic [BYTE_W-1:0] b, logic fin);
    int unsigned acc;
    int unsigned area;
    run_beat_t   tail;
    byte_runs.delete();
    // After the first error the rest of the chunk is dropped
    if (dec_err == ST_OK) begin
      case (dec_mode)
        MODE_SYM: begin
          dec_held = b;
          if (!symbol_allowed(b)) begin
            dec_err = ST_BAD_SYM;
          end else begin
            dec_mode   = MODE_DIG;
            dec_count  = '0;
            dec_digits = 1'b0;
          end
        end
        MODE_DIG: begin
          if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
            acc        = dec_count * 10 + (b - CHAR_ZERO);
            dec_count  = (acc > RUN_MAX) ? RUN_MAX : LEN_W'(acc);
            dec_digits = 1'b1;
          end else if (!dec_digits) begin
            dec_err = ST_MISSING;
          end else begin
            push_run(dec_held, dec_count);
            dec_count  = '0;
            dec_digits = 1'b0;
            dec_mode   = MODE_AFTER;
            take_element(b);
          end
        end
        default: take_element(b);
      endcase
    end
    if (fin) begin
      if (dec_err == ST_OK) begin
        if (dec_mode == MODE_SYM) begin
          dec_err = ST_MISSING;
        end else if (dec_mode == MODE_DIG) begin
          if (dec_digits) push_run(dec_held, dec_count);
          else dec_err = ST_MISSING;
        end
      end
      area = int'(cfg_width) * int'(cfg_height);
      if (dec_err == ST_OK) begin
        if (dec_line != cfg_width) dec_err = ST_LINE;
        else if (int'(dec_total) != area) dec_err = ST_SIZE;
      end
      // Status rides on the final run, or on a status-only beat
      if (byte_runs.size() == 0) begin
        tail = '0;
        byte_runs.insert(0, tail);
      end
      tail            = byte_runs[byte_runs.size() - 1];
      tail.status     = dec_err;
      tail.chunk_done = 1'b1;
      byte_runs[byte_runs.size() - 1] = tail;
      dec_mode   = MODE_FRESH;
      dec_held   = '0;
      dec_count  = '0;
      dec_digits = 1'b0;
      dec_line   = '0;
      dec_total  = '0;
      dec_err    = ST_OK;
    end
    if (byte_runs.size() > 0) begin
      tail           = byte_runs[byte_runs.size() - 1];
      tail.byte_last = 1'b1;
      byte_runs[byte_runs.size() - 1] = tail;
    end
    foreach (byte_runs[i]) run_expect_q.insert(run_expect_q.size(), byte_runs[i]);
  endfunction

  function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      fail_cnt++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: register writes, accepted bytes and result beats
  // ---------------------------------------------------------------------------

  run_beat_t head_run;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_if.index)
          CFG_MARKER:   cfg_marker   = cfg_if.data[BYTE_W-1:0];
          CFG_WIDTH:    cfg_width    = cfg_if.data[LC_W-1:0];
          CFG_HEIGHT:   cfg_height   = cfg_if.data[HGT_W-1:0];
          CFG_RULES:    cfg_rules    = cfg_if.data;
          CFG_RULE_CNT: cfg_rule_cnt = cfg_if.data[RCNT_W-1:0];
          default: ;
        endcase
      end
      // Predict before checking so a same-cycle result would still line up
      if (in_if.valid && in_if.ready) begin
        decode_byte(in_if.in_byte, in_if.chunk_end);
        bytes_taken++;
      end
      if (out_if.valid && out_if.ready) begin
        if (run_expect_q.size() == 0) begin
          fail_cnt++;
          $display("%0t: unexpected result beat, expected none, got symbol %0h %s %0d %s %0d",
                   $time, out_if.symbol, "run_length", out_if.run_length,
                   "status", out_if.status);
        end else begin
          head_run = run_expect_q.pop_front();
          check_field("symbol", head_run.symbol, out_if.symbol);
          check_field("run_length", head_run.run_length, out_if.run_length);
          check_field("status", head_run.status, out_if.status);
          check_field("chunk_done", head_run.chunk_done, out_if.chunk_done);
          check_field("last", head_run.byte_last, out_if.last);
        end
      end
    end
    byte_beat <= rst_ni && in_if.valid && in_if.ready;
  end

  // Watchdog: end the run when no beat moves on any channel for too long
  int unsigned quiet_cycles = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no progress for %0d cycles, %0d results outstanding",
                 $time, quiet_cycles, run_expect_q.size());
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender: bursts of random length with random gaps, fed from text_q
  // ---------------------------------------------------------------------------

  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;
  text_byte_t  next_byte;

  always @(negedge clk_i) begin
    // Only move on once the offered byte has been taken
    if (rst_ni && (!in_if.valid || byte_beat)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_if.valid <= 1'b0;
      end else if (text_q.size() > 0) begin
        next_byte = text_q.pop_front();
        in_if.valid     <= 1'b1;
        in_if.in_byte   <= next_byte.value;
        in_if.chunk_end <= next_byte.fin;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 48);
          // A third of the bursts run straight into the next one
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: rotating stall patterns, plus one long hold-off to fill the block
  // ---------------------------------------------------------------------------

  logic [15:0] stall_pat = '1;
  int unsigned pat_left  = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;

  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else if (!hold_done && bytes_taken >= HOLD_AT) begin
      // Hold results back while the sender keeps offering bytes
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      out_if.ready <= 1'b0;
    end else begin
      if (pat_left == 0) begin
        case ($urandom_range(0, 3))
          0:       stall_pat = '1;
          1:       stall_pat = 16'($urandom) | 16'h8000;
          2:       stall_pat = 16'($urandom & $urandom) | 16'h8000;
          default: stall_pat = 16'hF00F;
        endcase
        pat_left = $urandom_range(16, 160);
      end
      pat_left--;
      out_if.ready <= stall_pat[0];
      stall_pat = {stall_pat[0], stall_pat[15:1]};
    end
  end

  // ---------------------------------------------------------------------------
  // Chunk text generation
  // ---------------------------------------------------------------------------

  // Append one byte to the chunk under construction
  function automatic void add_txt(logic [BYTE_W-1:0] c);
    chunk_txt.insert(chunk_txt.size(), c);
  endfunction

  function automatic logic [BYTE_W-1:0] pick_sym();
    return sym_pool[$urandom_range(0, sym_pool.size() - 1)];
  endfunction

  // Marker, symbol and decimal count, sometimes with a leading zero
  function automatic void add_group(logic [BYTE_W-1:0] sym, int unsigned cnt);
    string digs;
    digs = $sformatf("%0d", cnt);
    add_txt(cfg_marker);
    add_txt(sym);
    if ($urandom_range(0, 5) == 0) add_txt(CHAR_ZERO);
    for (int i = 0; i < digs.len(); i++) add_txt(digs[i]);
  endfunction

  // Lines of exactly w symbols, h of them, no newline after the last
  function automatic void build_chunk(int unsigned w, int unsigned h);
    int unsigned left;
    int unsigned cnt;
    for (int unsigned ln = 0; ln < h; ln++) begin
      left = w;
      while (left > 0) begin
        if ($urandom_range(0, 9) == 0) add_group(pick_sym(), 0);
        if (left == 1 || $urandom_range(0, 1) == 0) begin
          add_txt(pick_sym());
          left--;
        end else begin
          cnt = $urandom_range(1, left);
          add_group(pick_sym(), cnt);
          left -= cnt;
        end
      end
      if (ln + 1 < h) add_txt(CHAR_NL);
    end
  endfunction

  // Break a well-formed chunk in one place
  function automatic void break_chunk();
    int unsigned keep;
    case ($urandom_range(0, 6))
      0: chunk_txt[$urandom_range(0, chunk_txt.size() - 1)] = BYTE_W'($urandom_range(0, 255));
      1: if (chunk_txt.size() > 1) chunk_txt.delete($urandom_range(0, chunk_txt.size() - 1));
      2: begin
        keep = $urandom_range(1, chunk_txt.size());
        while (chunk_txt.size() > keep) void'(chunk_txt.pop_back());
      end
      3: add_txt(CHAR_NL);
      4: add_txt(cfg_marker);
      5: begin
        add_txt(cfg_marker);
        add_txt(pick_sym());
      end
      default: add_group(pick_sym(), 999999);
    endcase
  endfunction

  function automatic void noise_chunk();
    repeat ($urandom_range(1, 12)) begin
      case ($urandom_range(0, 4))
        0:       add_txt(BYTE_W'($urandom_range(0, 255)));
        1:       add_txt(cfg_marker);
        2:       add_txt(CHAR_ZERO + BYTE_W'($urandom_range(0, 9)));
        3:       add_txt(CHAR_NL);
        default: add_txt(pick_sym());
      endcase
    end
  endfunction

  // Hand the chunk to the sender, flagging its final byte
  function automatic void queue_chunk();
    text_byte_t entry;
    foreach (chunk_txt[i]) begin
      entry.value = chunk_txt[i];
      entry.fin   = (i == chunk_txt.size() - 1);
      text_q.insert(text_q.size(), entry);
    end
    bytes_queued += chunk_txt.size();
    chunk_txt.delete();
  endfunction

  // ---------------------------------------------------------------------------
  // Register writes and phase sequencing
  // ---------------------------------------------------------------------------

  task automatic write_reg(cfg_idx_e idx, logic [RULES_W-1:0] val);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    @(posedge clk_i);
    while (cfg_if.ready !== 1'b1) @(posedge clk_i);
  endtask

  task automatic program_regs(logic [BYTE_W-1:0] mk, int unsigned w, int unsigned h,
                              logic [RULES_W-1:0] rl, int unsigned rc);
    logic [BYTE_W-1:0] r;
    write_reg(CFG_MARKER, RULES_W'(mk));
    write_reg(CFG_WIDTH, RULES_W'(w));
    write_reg(CFG_HEIGHT, RULES_W'(h));
    write_reg(CFG_RULES, rl);
    write_reg(CFG_RULE_CNT, RULES_W'(rc));
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
    // Symbols safe for well-formed text: no marker, digit or newline
    sym_pool.delete();
    sym_pool.insert(0, CHAR_SPACE);
    for (int k = 0; k < rc && k < MAX_RULES; k++) begin
      r = rl[BYTE_W*k +: BYTE_W];
      if (r != mk && r != CHAR_NL && r != CHAR_SPACE && !(r >= CHAR_ZERO && r <= CHAR_NINE)) begin
        sym_pool.insert(sym_pool.size(), r);
      end
    end
  endtask

  // Wait until every byte is taken and every result seen, then let the pipe drain
  task automatic settle();
    do @(negedge clk_i); while (bytes_taken != bytes_queued || run_expect_q.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  initial begin : stimulus
    logic [BYTE_W-1:0]  mk;
    logic [RULES_W-1:0] rl;
    int unsigned        w;
    int unsigned        h;
    int unsigned        rc;
    int unsigned        phase;
    int unsigned        start;
    int unsigned        pick;

    rst_ni          = 1'b0;
    in_if.valid     = 1'b0;
    in_if.in_byte   = '0;
    in_if.chunk_end = 1'b0;
    out_if.ready    = 1'b0;
    cfg_if.valid    = 1'b0;
    cfg_if.index    = CFG_MARKER;
    cfg_if.data     = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset values: with no rules, a newline opening a chunk is a bad symbol
    chunk_txt = '{CHAR_NL};
    queue_chunk();
    settle();

    // Directed: marker 0xFF, lines of 3, two lines, rules 'a' and 'b' only;
    // the unused rule bytes hold 'z' which must not count
    program_regs(DIR_MARK, 3, 2, 64'h7A7A_7A7A_7A7A_6261, 2);
    // Good chunk with a zero-count group, ending inside the digits
    chunk_txt = '{"a", DIR_MARK, "b", "2", CHAR_NL, DIR_MARK, " ", "0", DIR_MARK, "a", "3"};
    queue_chunk();
    // Chunk ends right after the marker, then right after the symbol
    chunk_txt = '{DIR_MARK};
    queue_chunk();
    chunk_txt = '{DIR_MARK, "a"};
    queue_chunk();
    // Trailing newline leaves an empty last line
    chunk_txt = '{"a", "a", "a", CHAR_NL};
    queue_chunk();
    // Symbol sitting in a rule byte beyond the count
    chunk_txt = '{"z"};
    queue_chunk();
    // Line is right but the chunk is one line short
    chunk_txt = '{"a", " ", "b"};
    queue_chunk();
    // Count saturates, then the line is far too long
    chunk_txt = '{DIR_MARK, "b", "9", "9", "9", "9", "9", "9"};
    queue_chunk();
    settle();

    // Random phases, a new register setting each, extremes first
    phase = 0;
    while (bytes_queued < ITEM_TARGET) begin
      rl = {$urandom, $urandom};
      rc = $urandom_range(0, MAX_RULES);
      w  = $urandom_range(1, 12);
      h  = $urandom_range(1, 6);
      do begin
        mk = BYTE_W'($urandom_range(0, 255));
      end while (mk == CHAR_SPACE || mk == CHAR_NL || (mk >= CHAR_ZERO && mk <= CHAR_NINE));
      if ($urandom_range(0, 4) == 0) rl[BYTE_W-1:0] = CHAR_NL;
      case (phase)
        0: begin
          mk = 8'h00;
          w  = MAX_WIDTH;
          h  = 1;
          rc = MAX_RULES;
        end
        1: begin
          mk = 8'hFF;
          w  = 1;
          h  = MAX_HEIGHT;
        end
        2: begin
          w  = 1;
          h  = 1;
          rc = 0;
        end
        3: begin
          w  = MAX_WIDTH;
          h  = 2;
          rc = 0;
        end
        default: ;
      endcase
      program_regs(mk, w, h, rl, rc);

      // Mostly well-formed chunks; the rest broken or plain noise
      start = bytes_queued;
      do begin
        pick = $urandom_range(0, 9);
        if (pick >= 8) begin
          noise_chunk();
        end else begin
          build_chunk(w, h);
          if (pick >= 6) break_chunk();
        end
        queue_chunk();
      end while (bytes_queued - start < PHASE_BYTES && h < MAX_HEIGHT);
      settle();
      phase++;
    end

    if (fail_cnt == 0 && run_expect_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/rtcd_pkg.sv
hw/rtl/rtcd_if.sv
hw/rtl/rtcd_front.sv
hw/rtl/rtcd_queue.sv
hw/rtl/rtcd_back.sv
hw/rtl/rle_text_chunk_decoder_top.sv
sim/tb.sv
